### src/ys2_pkg.sv
// Shared types for the YUV block to two-color block transcoder.
// Transaction payload structs, index layout codes and the decode bundle.
// No dependencies.
package ys2_pkg;

  // One input transaction: 16 YUV block bytes plus row flip
  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        flip_rows;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic [63:0] s2tc_block;
    logic        needs_fallback;
  } out_t;

  // Index row layout selected by the block header
  typedef enum logic [2:0] {
    LAY_ZERO,     // flat block, all indices zero
    LAY_ROW4,     // 4x1 rows of 2-bit codes in bytes 4..7
    LAY_ROW4_HI,  // 4x1 rows of 2-bit codes in bytes 12..15
    LAY_2X2,      // 2x2 codes in byte 6
    LAY_BIT1,     // 1 bit per pixel in bytes 6,7
    LAY_BIT3      // 3 bits per pixel in bytes 10..15
  } lay_e;

  // Decoded header: endpoint YUV values and layout
  typedef struct packed {
    logic signed [9:0] ya;
    logic signed [9:0] ua;
    logic signed [9:0] va;
    logic signed [9:0] yb;
    logic signed [9:0] ub;
    logic signed [9:0] vb;
    lay_e              lay;
    logic              fallback;
  } dec_t;

endpackage

### src/ys2_decode.sv
// Header decode: mode selection, deltas and endpoint YUV values.
// Depends on ys2_pkg.
module ys2_decode (
  input  ys2_pkg::in_t  blk_i,
  output ys2_pkg::dec_t dec_o
);

  localparam logic [7:0] MODE_FLAT    = 8'd0;
  localparam logic [7:0] MODE_2X2     = 8'd1;
  localparam logic [7:0] MODE_BIT1    = 8'd2;
  localparam logic [7:0] MODE_BIT3    = 8'd6;
  localparam logic [7:0] MODE_SKIP_A  = 8'd7;
  localparam logic [7:0] MODE_CD_ROW4 = 8'd14;
  localparam logic [7:0] MODE_CD_BIT3 = 8'd15;
  localparam logic [7:0] MODE_SKIP_B  = 8'd17;
  localparam logic [7:0] MODE_CD_2X2  = 8'd19;
  localparam logic [7:0] MODE_SKIP_C  = 8'd20;
  localparam logic [7:0] MODE_SKIP_D  = 8'd21;
  localparam logic [7:0] MODE_SKIP_E  = 8'd22;

  logic [7:0]        b0, b1, b2, b3, b4, b5, b8, b9;
  logic signed [9:0] cd, cdu, cdv;
  logic signed [9:0] cy, cu, cv;

  assign b0 = blk_i.block_low[7:0];
  assign b1 = blk_i.block_low[15:8];
  assign b2 = blk_i.block_low[23:16];
  assign b3 = blk_i.block_low[31:24];
  assign b4 = blk_i.block_low[39:32];
  assign b5 = blk_i.block_low[47:40];
  assign b8 = blk_i.block_high[7:0];
  assign b9 = blk_i.block_high[15:8];

  assign cy = signed'({2'b00, b0});
  assign cu = signed'({2'b00, b1});
  assign cv = signed'({2'b00, b2});

  // mode selection; chroma-delta modes use 2*(byte-128)
  always_comb begin
    cd             = '0;
    cdu            = '0;
    cdv            = '0;
    dec_o.lay      = ys2_pkg::LAY_ROW4;
    dec_o.fallback = 1'b0;
    if (b3 != 8'd0) begin
      cd = signed'({2'b00, b3});
    end else begin
      unique case (b4)
        MODE_FLAT: dec_o.lay = ys2_pkg::LAY_ZERO;
        MODE_SKIP_A, MODE_SKIP_B, MODE_SKIP_C, MODE_SKIP_D, MODE_SKIP_E: begin
          dec_o.fallback = 1'b1;
        end
        MODE_2X2, MODE_BIT1, MODE_BIT3: begin
          cd = signed'({2'b00, b5});
          unique case (b4)
            MODE_2X2:  dec_o.lay = ys2_pkg::LAY_2X2;
            MODE_BIT1: dec_o.lay = ys2_pkg::LAY_BIT1;
            default:   dec_o.lay = ys2_pkg::LAY_BIT3;
          endcase
        end
        MODE_CD_ROW4, MODE_CD_BIT3, MODE_CD_2X2: begin
          cd  = signed'({~b5[7], ~b5[7], b5[6:0], 1'b0});
          cdu = signed'({~b8[7], ~b8[7], b8[6:0], 1'b0});
          cdv = signed'({~b9[7], ~b9[7], b9[6:0], 1'b0});
          unique case (b4)
            MODE_CD_ROW4: dec_o.lay = ys2_pkg::LAY_ROW4_HI;
            MODE_CD_BIT3: dec_o.lay = ys2_pkg::LAY_BIT3;
            default:      dec_o.lay = ys2_pkg::LAY_2X2;
          endcase
        end
        default: ;  // unknown mode: plain delta block, delta zero
      endcase
    end

    // endpoints: base minus half delta, then plus full delta
    // (deltas are non-negative or even, so the shift is a halving rounded down)
    dec_o.ya = cy - (cd >>> 1);
    dec_o.ua = cu - (cdu >>> 1);
    dec_o.va = cv - (cdv >>> 1);
    dec_o.yb = dec_o.ya + cd;
    dec_o.ub = dec_o.ua + cdu;
    dec_o.vb = dec_o.va + cdv;
  end

endmodule

### src/ys2_color.sv
// YUV to RGB565 endpoint conversion in 8-bit fixed point, with bias and clamp.
// Depends on no package.
module ys2_color (
  input  logic signed [9:0] y_i,
  input  logic signed [9:0] u_i,
  input  logic signed [9:0] v_i,
  output logic [15:0]       rgb_o
);

  logic signed [23:0] y_e, up_e, vp_e;
  logic signed [23:0] r_acc, g_acc, b_acc;
  logic signed [15:0] r_s, g_s, b_s;
  logic [7:0]         r_c, g_c, b_c;

  function automatic logic [7:0] clamp8(input logic signed [15:0] x);
    logic [7:0] res;
    if (x < 16'sd0) begin
      res = 8'd0;
    end else if (x > 16'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // constant multiplies and rounding
  always_comb begin
    y_e   = 24'(y_i);
    up_e  = 24'(u_i) - 24'sd128;
    vp_e  = 24'(v_i) - 24'sd128;
    r_acc = (y_e <<< 8) + 24'sd359 * vp_e + 24'sd128;
    g_acc = (y_e <<< 8) - 24'sd88 * up_e - 24'sd183 * vp_e + 24'sd128;
    b_acc = (y_e <<< 8) + 24'sd454 * up_e + 24'sd128;
  end

  // floor divide by 256, bias, clamp and pack
  always_comb begin
    r_s   = r_acc[23:8] + 16'sd3;
    g_s   = g_acc[23:8] + 16'sd1;
    b_s   = b_acc[23:8] + 16'sd3;
    r_c   = clamp8(r_s);
    g_c   = clamp8(g_s);
    b_c   = clamp8(b_s);
    rgb_o = {r_c[7:3], g_c[7:2], b_c[7:3]};
  end

endmodule

### src/ys2_index.sv
// Index row generation for all layouts, in flip-aware row order.
// Depends on ys2_pkg.
module ys2_index (
  input  ys2_pkg::in_t  blk_i,
  input  ys2_pkg::lay_e lay_i,
  output logic [31:0]   rows_o
);

  // 4x1 row of 2-bit codes
  function automatic logic [7:0] row4(input logic [7:0] x, input logic alt);
    logic [7:0] r;
    r = '0;
    if (!alt) begin
      r[0] = (x[7:6] == 2'd3);
      r[2] = (x[5:4] >= 2'd2);
      r[4] = (x[3:2] == 2'd3);
      r[6] = (x[1:0] >= 2'd2);
    end else begin
      r[0] = (x[7:6] >= 2'd2);
      r[2] = (x[5:4] == 2'd3);
      r[4] = (x[3:2] >= 2'd2);
      r[6] = (x[1:0] == 2'd3);
    end
    return r;
  endfunction

  // 4x1 row of 3-bit codes
  function automatic logic [7:0] row3b(input logic [11:0] x, input logic alt);
    logic [7:0] r;
    r = '0;
    if (!alt) begin
      r[0] = (x[11:9] > 3'd6);
      r[2] = (x[8:6]  > 3'd2);
      r[4] = (x[5:3]  > 3'd6);
      r[6] = (x[2:0]  > 3'd2);
    end else begin
      r[0] = (x[11:9] > 3'd2);
      r[2] = (x[8:6]  > 3'd6);
      r[4] = (x[5:3]  > 3'd2);
      r[6] = (x[2:0]  > 3'd6);
    end
    return r;
  endfunction

  // four 1-bit pixels, MSB first
  function automatic logic [7:0] row1b(input logic [3:0] n);
    return {1'b0, n[0], 1'b0, n[1], 1'b0, n[2], 1'b0, n[3]};
  endfunction

  // 2x2 code pair expanded to a row
  function automatic logic [7:0] row22(input logic [1:0] pa, input logic [1:0] pb,
                                       input logic alt);
    logic s, t, w, z;
    logic [7:0] r;
    s = (pa == 2'd3);
    t = (pa >= 2'd2);
    w = (pb == 2'd3);
    z = (pb >= 2'd2);
    if (!alt) begin
      r = {1'b0, z, 1'b0, w, 1'b0, t, 1'b0, s};
    end else begin
      r = {1'b0, w, 1'b0, z, 1'b0, s, 1'b0, t};
    end
    return r;
  endfunction

  logic [7:0]  b [16];
  logic [7:0]  r [4];
  logic [7:0]  q [4];
  logic [15:0] p1;
  logic [23:0] wi, wj;
  logic        flip;

  // byte view of the block
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k]     = blk_i.block_low[8*k +: 8];
      b[k + 8] = blk_i.block_high[8*k +: 8];
    end
  end

  assign flip = blk_i.flip_rows;
  assign p1   = {b[6], b[7]};
  assign wi   = {b[10], b[11], b[12]};
  assign wj   = {b[13], b[14], b[15]};

  // per-layout rows
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r[k] = '0;
      q[k] = '0;
    end
    unique case (lay_i)
      ys2_pkg::LAY_ZERO: ;
      ys2_pkg::LAY_ROW4: begin
        for (int k = 0; k < 4; k++) begin
          r[k] = row4(flip ? b[7 - k] : b[4 + k], k[0]);
        end
      end
      ys2_pkg::LAY_ROW4_HI: begin
        for (int k = 0; k < 4; k++) begin
          r[k] = row4(flip ? b[15 - k] : b[12 + k], k[0]);
        end
      end
      ys2_pkg::LAY_2X2: begin
        q[0] = row22(b[6][7:6], b[6][5:4], 1'b0);
        q[1] = row22(b[6][7:6], b[6][5:4], 1'b1);
        q[2] = row22(b[6][3:2], b[6][1:0], 1'b0);
        q[3] = row22(b[6][3:2], b[6][1:0], 1'b1);
        for (int k = 0; k < 4; k++) begin
          r[k] = flip ? q[3 - k] : q[k];
        end
      end
      ys2_pkg::LAY_BIT1: begin
        for (int k = 0; k < 4; k++) begin
          r[k] = row1b(flip ? p1[4*k +: 4] : p1[(12 - 4*k) +: 4]);
        end
      end
      ys2_pkg::LAY_BIT3: begin
        if (flip) begin
          r[0] = row3b(wj[11:0],  1'b0);
          r[1] = row3b(wj[23:12], 1'b1);
          r[2] = row3b(wi[11:0],  1'b0);
          r[3] = row3b(wi[23:12], 1'b1);
        end else begin
          r[0] = row3b(wi[23:12], 1'b0);
          r[1] = row3b(wi[11:0],  1'b1);
          r[2] = row3b(wj[23:12], 1'b0);
          r[3] = row3b(wj[11:0],  1'b1);
        end
      end
      default: ;
    endcase
  end

  assign rows_o = {r[3], r[2], r[1], r[0]};

endmodule

### src/yuv_block_to_s2tc_transcode.sv
// Top level of the YUV block to two-color 4x4 block transcoder.
// Depends on ys2_pkg, ys2_decode, ys2_color and ys2_index.

// A block is taken whenever start is high; busy never rises, so one block per
// clock is sustained. Each transaction gives exactly one result, shown for one
// cycle with done_o high: the block goes from the input register through header
// decode, the two YUV to RGB565 converters and the index logic into the result
// register. The receiver cannot stall, so it must capture every result in the
// cycle it appears. Left-out modes return an all-zero block with needs_fallback
// set.
module yuv_block_to_s2tc_transcode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ys2_pkg::in_t  blk_i,
  output logic          done_o,
  output ys2_pkg::out_t res_o
);

  ys2_pkg::in_t  in_q;
  logic          in_vld_q;
  ys2_pkg::dec_t dec;
  logic [15:0]   e0, e1;
  logic [31:0]   rows;
  ys2_pkg::out_t res_d, res_q;
  logic          done_q;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= blk_i;
    end
  end

  ys2_decode u_decode (
    .blk_i (in_q),
    .dec_o (dec)
  );

  ys2_color u_color_a (
    .y_i   (dec.ya),
    .u_i   (dec.ua),
    .v_i   (dec.va),
    .rgb_o (e0)
  );

  ys2_color u_color_b (
    .y_i   (dec.yb),
    .u_i   (dec.ub),
    .v_i   (dec.vb),
    .rgb_o (e1)
  );

  ys2_index u_index (
    .blk_i  (in_q),
    .lay_i  (dec.lay),
    .rows_o (rows)
  );

  // result assembly
  always_comb begin
    res_d.needs_fallback = dec.fallback;
    res_d.s2tc_block     = dec.fallback ? 64'd0 : {rows, e1, e0};
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
